FILE: sv/oms_pkg.sv
// Shared types, constants and gain tables for the object motion step pipeline.
// No dependencies; imported by oms_gain_mul and object_motion_step_core.
`default_nettype none

package oms_pkg;

    // Motion mode codes
    localparam logic [7:0] MODE_WALK = 8'h01;
    localparam logic [7:0] MODE_VEL  = 8'h02;

    // Field widths
    localparam int unsigned GAIN_W = 13;   // largest gain 0x1400 needs 13 bits
    localparam int unsigned SPD_W  = 8;
    localparam int unsigned PROD_W = GAIN_W + SPD_W;
    localparam int unsigned POS_W  = 32;
    localparam int unsigned VEL_W  = 16;
    localparam int unsigned IDX_W  = 7;    // table index 0..64

    // Quarter-wave index constants
    localparam logic [IDX_W-1:0] QUARTER = 7'd64;

    // Per-item control carried down the pipeline
    typedef struct packed {
        logic walk;     // polar walk step applies
        logic neg_x;    // X step is subtracted
        logic neg_y;    // Y step is subtracted
    } t_ctrl;

    // Quarter-wave sine table, scaled by 5120
    function automatic logic [GAIN_W-1:0] sin_gain(input logic [IDX_W-1:0] idx);
        logic [GAIN_W-1:0] g;
        case (idx)
            7'd0:  g = 13'h0000;  7'd1:  g = 13'h007E;  7'd2:  g = 13'h00FB;
            7'd3:  g = 13'h0179;  7'd4:  g = 13'h01F6;  7'd5:  g = 13'h0273;
            7'd6:  g = 13'h02EF;  7'd7:  g = 13'h036B;  7'd8:  g = 13'h03E7;
            7'd9:  g = 13'h0462;  7'd10: g = 13'h04DC;  7'd11: g = 13'h0556;
            7'd12: g = 13'h05CE;  7'd13: g = 13'h0646;  7'd14: g = 13'h06BD;
            7'd15: g = 13'h0733;  7'd16: g = 13'h07A7;  7'd17: g = 13'h081B;
            7'd18: g = 13'h088D;  7'd19: g = 13'h08FE;  7'd20: g = 13'h096E;
            7'd21: g = 13'h09DC;  7'd22: g = 13'h0A48;  7'd23: g = 13'h0AB3;
            7'd24: g = 13'h0B1D;  7'd25: g = 13'h0B84;  7'd26: g = 13'h0BEA;
            7'd27: g = 13'h0C4E;  7'd28: g = 13'h0CB0;  7'd29: g = 13'h0D10;
            7'd30: g = 13'h0D6E;  7'd31: g = 13'h0DCA;  7'd32: g = 13'h0E24;
            7'd33: g = 13'h0E7C;  7'd34: g = 13'h0ED2;  7'd35: g = 13'h0F25;
            7'd36: g = 13'h0F76;  7'd37: g = 13'h0FC4;  7'd38: g = 13'h1010;
            7'd39: g = 13'h105A;  7'd40: g = 13'h10A1;  7'd41: g = 13'h10E6;
            7'd42: g = 13'h1128;  7'd43: g = 13'h1167;  7'd44: g = 13'h11A3;
            7'd45: g = 13'h11DD;  7'd46: g = 13'h1214;  7'd47: g = 13'h1249;
            7'd48: g = 13'h127A;  7'd49: g = 13'h12A9;  7'd50: g = 13'h12D5;
            7'd51: g = 13'h12FE;  7'd52: g = 13'h1324;  7'd53: g = 13'h1347;
            7'd54: g = 13'h1367;  7'd55: g = 13'h1384;  7'd56: g = 13'h139E;
            7'd57: g = 13'h13B5;  7'd58: g = 13'h13C9;  7'd59: g = 13'h13D9;
            7'd60: g = 13'h13E7;  7'd61: g = 13'h13F2;  7'd62: g = 13'h13FA;
            7'd63: g = 13'h13FE;  7'd64: g = 13'h1400;
            default: g = '0;
        endcase
        return g;
    endfunction

    // Quarter-wave cosine table, scaled by 4096
    function automatic logic [GAIN_W-1:0] cos_gain(input logic [IDX_W-1:0] idx);
        logic [GAIN_W-1:0] g;
        case (idx)
            7'd0:  g = 13'h1000;  7'd1:  g = 13'h0FFF;  7'd2:  g = 13'h0FFB;
            7'd3:  g = 13'h0FF5;  7'd4:  g = 13'h0FEC;  7'd5:  g = 13'h0FE1;
            7'd6:  g = 13'h0FD4;  7'd7:  g = 13'h0FC4;  7'd8:  g = 13'h0FB1;
            7'd9:  g = 13'h0F9C;  7'd10: g = 13'h0F85;  7'd11: g = 13'h0F6C;
            7'd12: g = 13'h0F50;  7'd13: g = 13'h0F31;  7'd14: g = 13'h0F11;
            7'd15: g = 13'h0EEE;  7'd16: g = 13'h0EC8;  7'd17: g = 13'h0EA1;
            7'd18: g = 13'h0E77;  7'd19: g = 13'h0E4B;  7'd20: g = 13'h0E1C;
            7'd21: g = 13'h0DEC;  7'd22: g = 13'h0DB9;  7'd23: g = 13'h0D85;
            7'd24: g = 13'h0D4E;  7'd25: g = 13'h0D15;  7'd26: g = 13'h0CDA;
            7'd27: g = 13'h0C9B;  7'd28: g = 13'h0C5E;  7'd29: g = 13'h0C1E;
            7'd30: g = 13'h0BDB;  7'd31: g = 13'h0B97;  7'd32: g = 13'h0B50;
            7'd33: g = 13'h0B08;  7'd34: g = 13'h0ABF;  7'd35: g = 13'h0A73;
            7'd36: g = 13'h0A26;  7'd37: g = 13'h09D8;  7'd38: g = 13'h0988;
            7'd39: g = 13'h0937;  7'd40: g = 13'h08E4;  7'd41: g = 13'h088F;
            7'd42: g = 13'h083A;  7'd43: g = 13'h07E3;  7'd44: g = 13'h078B;
            7'd45: g = 13'h0732;  7'd46: g = 13'h06D7;  7'd47: g = 13'h067C;
            7'd48: g = 13'h061F;  7'd49: g = 13'h05C2;  7'd50: g = 13'h0564;
            7'd51: g = 13'h0505;  7'd52: g = 13'h04A5;  7'd53: g = 13'h0444;
            7'd54: g = 13'h03E3;  7'd55: g = 13'h0381;  7'd56: g = 13'h031F;
            7'd57: g = 13'h02BC;  7'd58: g = 13'h0259;  7'd59: g = 13'h01F5;
            7'd60: g = 13'h0191;  7'd61: g = 13'h012D;  7'd62: g = 13'h00C9;
            7'd63: g = 13'h0065;  7'd64: g = 13'h0000;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: sv/oms_gain_mul.sv
// Registered speed multiplier for the X and Y walk gains (pipeline stage 2).
// Depends on oms_pkg for field widths.
`default_nettype none

module oms_gain_mul
    import oms_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [GAIN_W-1:0] i_gain_x,
    input  wire logic [GAIN_W-1:0] i_gain_y,
    input  wire logic [SPD_W-1:0]  i_speed,
    output logic      [PROD_W-1:0] o_prod_x,
    output logic      [PROD_W-1:0] o_prod_y
);

    logic [PROD_W-1:0] r_prod_x;
    logic [PROD_W-1:0] r_prod_y;
    logic [PROD_W-1:0] n_prod_x;
    logic [PROD_W-1:0] n_prod_y;

    // Scale both gains by the speed
    always_comb begin
        n_prod_x = PROD_W'(i_gain_x) * PROD_W'(i_speed);
        n_prod_y = PROD_W'(i_gain_y) * PROD_W'(i_speed);
    end

    // Hold products while the stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
        end
    end

    assign o_prod_x = r_prod_x;
    assign o_prod_y = r_prod_y;

endmodule

`default_nettype wire

FILE: sv/object_motion_step_core.sv
// Channel  | direction | handshake                | payload
// request  | in        | i_in_valid / o_in_ready  | mode, heading, speed, pos, vel, gravity
// result   | out       | o_out_valid / i_out_ready| new_x, new_y, new_z, new_vel_z
//
// Three-stage pipeline: table lookup and velocity add, speed multiply, walk add.
// One request is taken every cycle while results drain.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// close up and a stall on the result side holds everything in place.
// Synchronous active-low reset clears the stage valid bits only.
// Depends on oms_pkg and oms_gain_mul.
`default_nettype none

module object_motion_step_core
    import oms_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic        [7:0]  i_mode,
    input  wire logic        [7:0]  i_heading,
    input  wire logic        [7:0]  i_step_speed,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [15:0] i_vel_x,
    input  wire logic signed [15:0] i_vel_y,
    input  wire logic signed [15:0] i_vel_z,
    input  wire logic        [15:0] i_gravity,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_new_x,
    output logic signed [31:0]      o_new_y,
    output logic signed [31:0]      o_new_z,
    output logic signed [15:0]      o_new_vel_z
);

    // Stage valid bits and enables
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3        = !r_v3 || i_out_ready;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // Stage 1: decode heading, look up gains, apply velocity mode
    logic [1:0]        quad;
    logic [5:0]        low;
    logic [IDX_W-1:0]  idx;
    logic              is_vel;
    t_ctrl             n_ctrl1;
    logic [POS_W-1:0]  n_x1, n_y1, n_z1;
    logic [VEL_W-1:0]  n_vz1;

    always_comb begin
        quad          = i_heading[7:6];
        low           = i_heading[5:0];
        idx           = quad[0] ? (QUARTER - {1'b0, low}) : {1'b0, low};
        is_vel        = (i_mode == MODE_VEL);
        n_ctrl1.walk  = (i_mode == MODE_WALK);
        n_ctrl1.neg_x = quad[1];
        n_ctrl1.neg_y = quad[1] ^ quad[0];
        n_x1  = i_pos_x;
        n_y1  = i_pos_y;
        n_z1  = i_pos_z;
        n_vz1 = i_vel_z;
        if (is_vel) begin
            n_x1  = i_pos_x + {{8{i_vel_x[15]}}, i_vel_x, 8'h00};
            n_y1  = i_pos_y + {{8{i_vel_y[15]}}, i_vel_y, 8'h00};
            n_z1  = i_pos_z + {{8{i_vel_z[15]}}, i_vel_z, 8'h00};
            n_vz1 = i_vel_z - i_gravity;
        end
    end

    t_ctrl             r_ctrl1;
    logic [GAIN_W-1:0] r_gx1, r_gy1;
    logic [SPD_W-1:0]  r_spd1;
    logic [POS_W-1:0]  r_x1, r_y1, r_z1;
    logic [VEL_W-1:0]  r_vz1;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_ctrl1 <= n_ctrl1;
            r_gx1   <= sin_gain(idx);
            r_gy1   <= cos_gain(idx);
            r_spd1  <= i_step_speed;
            r_x1    <= n_x1;
            r_y1    <= n_y1;
            r_z1    <= n_z1;
            r_vz1   <= n_vz1;
        end
    end

    // Stage 2: scale gains by speed, carry the record along
    logic [PROD_W-1:0] prod_x, prod_y;

    oms_gain_mul u_mul (
        .i_clk    (i_clk),
        .i_en     (en2),
        .i_gain_x (r_gx1),
        .i_gain_y (r_gy1),
        .i_speed  (r_spd1),
        .o_prod_x (prod_x),
        .o_prod_y (prod_y)
    );

    t_ctrl            r_ctrl2;
    logic [POS_W-1:0] r_x2, r_y2, r_z2;
    logic [VEL_W-1:0] r_vz2;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_ctrl2 <= r_ctrl1;
            r_x2    <= r_x1;
            r_y2    <= r_y1;
            r_z2    <= r_z1;
            r_vz2   <= r_vz1;
        end
    end

    // Stage 3: add or subtract the walk step, wrapping
    logic [POS_W-1:0] step_x, step_y;
    logic [POS_W-1:0] n_x3, n_y3;

    always_comb begin
        step_x = POS_W'(prod_x);
        step_y = POS_W'(prod_y);
        n_x3   = r_x2;
        n_y3   = r_y2;
        if (r_ctrl2.walk) begin
            n_x3 = r_ctrl2.neg_x ? (r_x2 - step_x) : (r_x2 + step_x);
            n_y3 = r_ctrl2.neg_y ? (r_y2 - step_y) : (r_y2 + step_y);
        end
    end

    logic [POS_W-1:0] r_x3, r_y3, r_z3;
    logic [VEL_W-1:0] r_vz3;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_x3  <= n_x3;
            r_y3  <= n_y3;
            r_z3  <= r_z2;
            r_vz3 <= r_vz2;
        end
    end

    assign o_out_valid = r_v3;
    assign o_new_x     = r_x3;
    assign o_new_y     = r_y3;
    assign o_new_z     = r_z3;
    assign o_new_vel_z = r_vz3;

endmodule

`default_nettype wire

FILE: sv/oms_checker.sv
// Port-level checks for object_motion_step_core, bound to every instance.
// Tracks requests in flight from the handshakes alone; depends on no package.
`default_nettype none

module oms_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [31:0] o_new_x,
    input wire logic signed [31:0] o_new_y,
    input wire logic signed [31:0] o_new_z,
    input wire logic signed [15:0] o_new_vel_z
);

    logic       in_take;
    logic       out_take;
    logic [2:0] r_inflight;

    assign in_take  = i_in_valid && o_in_ready;
    assign out_take = o_out_valid && i_out_ready;

    // Count requests accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 3'd0;
        end else begin
            r_inflight <= r_inflight + 3'(in_take) - 3'(out_take);
        end
    end

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_new_x) &&
            $stable(o_new_y) && $stable(o_new_z) && $stable(o_new_vel_z))
        else $error("stalled result changed");

    // No result without a request in flight
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight == 3'd0 |-> !o_out_valid)
        else $error("result with nothing in flight");

    // Pipeline holds at most three requests
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd3)
        else $error("more than three requests in flight");

    // Ready stays high while any stage is free
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight < 3'd3 |-> o_in_ready)
        else $error("request refused with a free stage");

endmodule

bind object_motion_step_core oms_checker u_oms_checker (.*);

`default_nettype wire

FILE: bench/tb_object_motion_step_core.sv
`timescale 1ns / 100ps
// Self-checking bench for object_motion_step_core: directed and random motion records,
// with a scoreboard class that predicts each update. Depends on oms_pkg and the core RTL.

module tb_object_motion_step_core;
    import oms_pkg::*;

    localparam int unsigned RANDOM_RECORDS = 1030;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned IDLE_PCT       = 11;

    // Heading quadrants, clockwise from +y
    localparam logic [1:0] QUAD_NE = 2'd0;
    localparam logic [1:0] QUAD_SE = 2'd1;
    localparam logic [1:0] QUAD_SW = 2'd2;
    localparam logic [1:0] QUAD_NW = 2'd3;

    // Mode codes outside the two motion kinds
    localparam logic [7:0] MODE_IDLE = 8'h00;
    localparam logic [7:0] MODE_TOP  = 8'hFF;

    // X step gain per quarter-wave index: 5120 * sin
    localparam logic [0:64][15:0] SIN_STEP_GAIN = {
        16'h0000, 16'h007E, 16'h00FB, 16'h0179, 16'h01F6, 16'h0273, 16'h02EF, 16'h036B,
        16'h03E7, 16'h0462, 16'h04DC, 16'h0556, 16'h05CE, 16'h0646, 16'h06BD, 16'h0733,
        16'h07A7, 16'h081B, 16'h088D, 16'h08FE, 16'h096E, 16'h09DC, 16'h0A48, 16'h0AB3,
        16'h0B1D, 16'h0B84, 16'h0BEA, 16'h0C4E, 16'h0CB0, 16'h0D10, 16'h0D6E, 16'h0DCA,
        16'h0E24, 16'h0E7C, 16'h0ED2, 16'h0F25, 16'h0F76, 16'h0FC4, 16'h1010, 16'h105A,
        16'h10A1, 16'h10E6, 16'h1128, 16'h1167, 16'h11A3, 16'h11DD, 16'h1214, 16'h1249,
        16'h127A, 16'h12A9, 16'h12D5, 16'h12FE, 16'h1324, 16'h1347, 16'h1367, 16'h1384,
        16'h139E, 16'h13B5, 16'h13C9, 16'h13D9, 16'h13E7, 16'h13F2, 16'h13FA, 16'h13FE,
        16'h1400
    };

    // Y step gain per quarter-wave index: 4096 * cos
    localparam logic [0:64][15:0] COS_STEP_GAIN = {
        16'h1000, 16'h0FFF, 16'h0FFB, 16'h0FF5, 16'h0FEC, 16'h0FE1, 16'h0FD4, 16'h0FC4,
        16'h0FB1, 16'h0F9C, 16'h0F85, 16'h0F6C, 16'h0F50, 16'h0F31, 16'h0F11, 16'h0EEE,
        16'h0EC8, 16'h0EA1, 16'h0E77, 16'h0E4B, 16'h0E1C, 16'h0DEC, 16'h0DB9, 16'h0D85,
        16'h0D4E, 16'h0D15, 16'h0CDA, 16'h0C9B, 16'h0C5E, 16'h0C1E, 16'h0BDB, 16'h0B97,
        16'h0B50, 16'h0B08, 16'h0ABF, 16'h0A73, 16'h0A26, 16'h09D8, 16'h0988, 16'h0937,
        16'h08E4, 16'h088F, 16'h083A, 16'h07E3, 16'h078B, 16'h0732, 16'h06D7, 16'h067C,
        16'h061F, 16'h05C2, 16'h0564, 16'h0505, 16'h04A5, 16'h0444, 16'h03E3, 16'h0381,
        16'h031F, 16'h02BC, 16'h0259, 16'h01F5, 16'h0191, 16'h012D, 16'h00C9, 16'h0065,
        16'h0000
    };

    typedef struct packed {
        logic [7:0]  mode;
        logic [7:0]  heading;
        logic [7:0]  step_speed;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [15:0] vel_x;
        logic [15:0] vel_y;
        logic [15:0] vel_z;
        logic [15:0] gravity;
    } motion_req_t;

    typedef struct packed {
        logic [31:0] new_x;
        logic [31:0] new_y;
        logic [31:0] new_z;
        logic [15:0] new_vel_z;
    } motion_res_t;

    // Predict object updates and match them against results in order
    class motion_scoreboard;
        motion_res_t expected_updates[$];
        int unsigned fail_count;
        int unsigned results_seen;

        function motion_res_t predict_motion(motion_req_t req);
            motion_res_t res;
            logic [1:0]       quad;
            logic [IDX_W-1:0] idx;
            logic [31:0]      dx;
            logic [31:0]      dy;
            res.new_x     = req.pos_x;
            res.new_y     = req.pos_y;
            res.new_z     = req.pos_z;
            res.new_vel_z = req.vel_z;
            if (req.mode == MODE_WALK) begin
                // mirror the index in the odd quadrants, sign the steps per quadrant
                quad = req.heading[7:6];
                idx  = {1'b0, req.heading[5:0]};
                if (quad == QUAD_SE || quad == QUAD_NW)
                    idx = QUARTER - idx;
                dx = 32'(SIN_STEP_GAIN[idx]) * 32'(req.step_speed);
                dy = 32'(COS_STEP_GAIN[idx]) * 32'(req.step_speed);
                if (quad == QUAD_SW || quad == QUAD_NW)
                    dx = -dx;
                if (quad == QUAD_SE || quad == QUAD_SW)
                    dy = -dy;
                res.new_x = req.pos_x + dx;
                res.new_y = req.pos_y + dy;
            end else if (req.mode == MODE_VEL) begin
                // 8.8 velocity moved into 16.16, then gravity off the Z velocity
                res.new_x     = req.pos_x + {{8{req.vel_x[15]}}, req.vel_x, 8'h00};
                res.new_y     = req.pos_y + {{8{req.vel_y[15]}}, req.vel_y, 8'h00};
                res.new_z     = req.pos_z + {{8{req.vel_z[15]}}, req.vel_z, 8'h00};
                res.new_vel_z = req.vel_z - req.gravity;
            end
            return res;
        endfunction

        function void note_request(motion_req_t req);
            expected_updates.push_back(predict_motion(req));
        endfunction

        function int unsigned pending();
            return expected_updates.size();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            fail_count++;
        endtask

        task check_result(motion_res_t seen);
            motion_res_t want;
            results_seen++;
            if (expected_updates.size() == 0) begin
                report($sformatf("result %0d with nothing outstanding", results_seen));
                return;
            end
            want = expected_updates.pop_front();
            if (seen.new_x !== want.new_x)
                report($sformatf("result %0d new_x %h, want %h",
                                 results_seen, seen.new_x, want.new_x));
            if (seen.new_y !== want.new_y)
                report($sformatf("result %0d new_y %h, want %h",
                                 results_seen, seen.new_y, want.new_y));
            if (seen.new_z !== want.new_z)
                report($sformatf("result %0d new_z %h, want %h",
                                 results_seen, seen.new_z, want.new_z));
            if (seen.new_vel_z !== want.new_vel_z)
                report($sformatf("result %0d new_vel_z %h, want %h",
                                 results_seen, seen.new_vel_z, want.new_vel_z));
        endtask
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_ready;
    logic        [7:0]  i_mode       = '0;
    logic        [7:0]  i_heading    = '0;
    logic        [7:0]  i_step_speed = '0;
    logic signed [31:0] i_pos_x      = '0;
    logic signed [31:0] i_pos_y      = '0;
    logic signed [31:0] i_pos_z      = '0;
    logic signed [15:0] i_vel_x      = '0;
    logic signed [15:0] i_vel_y      = '0;
    logic signed [15:0] i_vel_z      = '0;
    logic        [15:0] i_gravity    = '0;
    logic               o_out_valid;
    logic               i_out_ready  = 1'b0;
    logic signed [31:0] o_new_x;
    logic signed [31:0] o_new_y;
    logic signed [31:0] o_new_z;
    logic signed [15:0] o_new_vel_z;

    motion_scoreboard sb = new();
    bit calm_phase    = 1'b0;   // no idling on either side
    bit stall_results = 1'b0;   // ask the result side for one long hold-off

    object_motion_step_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_heading    (i_heading),
        .i_step_speed (i_step_speed),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_vel_x      (i_vel_x),
        .i_vel_y      (i_vel_y),
        .i_vel_z      (i_vel_z),
        .i_gravity    (i_gravity),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_new_x      (o_new_x),
        .o_new_y      (o_new_y),
        .o_new_z      (o_new_z),
        .o_new_vel_z  (o_new_vel_z)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Favor the wrap points of a 32-bit position
    function automatic logic [31:0] pick_position();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Favor the extremes of an 8.8 velocity
    function automatic logic [15:0] pick_velocity();
        case ($urandom_range(11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one request after an optional drain and random idling, and hold it until taken
    task automatic send_request(input motion_req_t req, input bit drain_first);
        if (drain_first) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (sb.pending() != 0);
        end
        while (!calm_phase && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= req.mode;
        i_heading    <= req.heading;
        i_step_speed <= req.step_speed;
        i_pos_x      <= req.pos_x;
        i_pos_y      <= req.pos_y;
        i_pos_z      <= req.pos_z;
        i_vel_x      <= req.vel_x;
        i_vel_y      <= req.vel_y;
        i_vel_z      <= req.vel_z;
        i_gravity    <= req.gravity;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
    endtask

    task automatic send_record(input logic [7:0] mode, input logic [7:0] heading,
                               input logic [7:0] speed, input logic [31:0] px,
                               input logic [31:0] py, input logic [31:0] pz,
                               input logic [15:0] vx, input logic [15:0] vy,
                               input logic [15:0] vz, input logic [15:0] grav);
        motion_req_t req;
        req = '{mode, heading, speed, px, py, pz, vx, vy, vz, grav};
        send_request(req, 1'b0);
    endtask

    // Request side: reset, directed records, random records, drain
    initial begin : request_side
        motion_req_t req;
        int unsigned pick;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // polar walk mostly at the quadrant edges and full speed, some positions near the wrap
        send_record(MODE_WALK, 8'd0,   8'd255, 32'h0,         32'h7FFF_FFFF, 32'h1234_5678,
                    16'h1111, 16'h2222, 16'h8000, 16'hFFFF);
        send_record(MODE_WALK, 8'd63,  8'd255, 32'h7FFF_F000, 32'h0, 32'h0,
                    16'h0, 16'h0, 16'h7FFF, 16'h0001);
        send_record(MODE_WALK, 8'd64,  8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                    16'h0, 16'h0, 16'h0, 16'h0);
        send_record(MODE_WALK, 8'd65,  8'd255, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                    16'h0);
        send_record(MODE_WALK, 8'd127, 8'd255, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                    16'h0);
        send_record(MODE_WALK, 8'd128, 8'd255, 32'h8000_0000, 32'h8000_0000, 32'h0,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_record(MODE_WALK, 8'd129, 8'd200, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                    16'h0);
        send_record(MODE_WALK, 8'd191, 8'd255, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                    16'h0);
        send_record(MODE_WALK, 8'd192, 8'd255, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                    16'h0, 16'h0, 16'h0, 16'h0);
        send_record(MODE_WALK, 8'd193, 8'd1,   32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                    16'h0);
        send_record(MODE_WALK, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                    16'h7FFF, 16'h8000, 16'h1234, 16'h8000);
        send_record(MODE_WALK, 8'd200, 8'd0,   32'h1357_9BDF, 32'h2468_ACE0, 32'h5555_AAAA,
                    16'h0, 16'h0, 16'hAAAA, 16'h5555);

        // velocity step at the extremes, gravity wrap in both directions
        send_record(MODE_VEL, 8'hFF, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_0000,
                    16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF);
        send_record(MODE_VEL, 8'h00, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                    16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000);
        send_record(MODE_VEL, 8'h5A, 8'hA5, 32'h0, 32'h0, 32'hFFFF_FFFF,
                    16'hFFFF, 16'h0001, 16'h0000, 16'h0001);
        send_record(MODE_VEL, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                    16'h0000, 16'h0000, 16'h7FFF, 16'h8000);

        // other modes pass the record through
        send_record(MODE_IDLE, 8'd64, 8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
                    16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF);
        send_record(8'h03, 8'd128, 8'd255, 32'h1, 32'h2, 32'h3, 16'h4, 16'h5, 16'h6,
                    16'hFFFF);
        send_record(8'h80, 8'd32, 8'd17, 32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h0BAD_F00D,
                    16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        send_record(MODE_TOP, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        for (int unsigned n = 0; n < RANDOM_RECORDS; n++) begin
            // one long result hold-off, one stretch with no idling
            if (n == 150)
                stall_results = 1'b1;
            calm_phase = (n >= 350 && n < 550);

            pick = $urandom_range(99);
            if (pick < 42)
                req.mode = MODE_WALK;
            else if (pick < 84)
                req.mode = MODE_VEL;
            else begin
                req.mode = 8'($urandom_range(255));
                if (req.mode == MODE_WALK || req.mode == MODE_VEL)
                    req.mode = MODE_IDLE;
            end
            req.heading = 8'($urandom_range(255));
            case ($urandom_range(9))
                0:       req.step_speed = 8'd0;
                1:       req.step_speed = 8'd255;
                default: req.step_speed = 8'($urandom_range(255));
            endcase
            req.pos_x   = pick_position();
            req.pos_y   = pick_position();
            req.pos_z   = pick_position();
            req.vel_x   = pick_velocity();
            req.vel_y   = pick_velocity();
            req.vel_z   = pick_velocity();
            req.gravity = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
            // pause once until every update is back
            send_request(req, n == 700);
        end
        i_in_valid <= 1'b0;

        // drain, then allow for the pipeline depth
        for (int unsigned g = 0; g < 20000 && sb.pending() != 0; g++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d updates never came back", sb.pending()));
        if (sb.fail_count == 0)
            $display("object_motion_step_core regression: pass");
        else
            $display("object_motion_step_core regression: fail");
        $finish;
    end

    // Result side: check each taken result, pick the next ready
    initial begin : result_side
        motion_res_t seen;
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                seen.new_x     = o_new_x;
                seen.new_y     = o_new_y;
                seen.new_z     = o_new_z;
                seen.new_vel_z = o_new_vel_z;
                sb.check_result(seen);
            end
            if (stall_results) begin
                hold_left     = HOLD_CYCLES;
                stall_results = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm_phase || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Guard against a hung pipeline
    initial begin : watchdog
        #2_000_000;
        $display("object_motion_step_core regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
sv/oms_pkg.sv
sv/oms_gain_mul.sv
sv/object_motion_step_core.sv
sv/oms_checker.sv
bench/tb_object_motion_step_core.sv
